### rtl/cfp_pkg.sv
package cfp_pkg;

  // field widths of the request and response
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CNT_W  = 5;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_HWM   = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] push_data;
    logic [IDX_W-1:0]  peek_index;
  } in_req_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  entry_count;
    logic              is_full;
    logic              is_empty;
    logic              sticky_error;
    logic [CNT_W-1:0]  high_water;
  } out_rsp_t;

endpackage

### rtl/cfp_ram.sv
module cfp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/circular_fifo_with_peek_unit.sv
// Ring-buffer FIFO of 32-bit words with push, pop, peek at a distance from the head, clear and
// a read-and-reset high-water mark. Each request returns one response with status, data, count,
// full and empty flags and a sticky error flag. Requests go through a two-stage path: the first
// stage updates head, tail, count and flags and addresses the slot RAM, the second picks up the
// registered RAM read data into the response register. One request is taken per clock cycle
// unless the response stage stalls, limited by the read-modify-write of the control registers
// around the RAM; a response passes through the stage and response registers. Writing the capacity
// register empties the queue; 0 is taken as 1, above min(DEPTH,31) as that. Write it only while idle.
module circular_fifo_with_peek_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  cfp_pkg::in_req_t                     in_req_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output cfp_pkg::out_rsp_t                    out_rsp_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cfp_pkg::CNT_W-1:0]            cfg_data_i
);

  localparam int unsigned PW      = $clog2(DEPTH);
  localparam int unsigned SW      = (PW > cfp_pkg::CNT_W) ? PW : cfp_pkg::CNT_W;
  localparam int unsigned SumW    = SW + 1;
  localparam int unsigned CapMaxI = (DEPTH > 31) ? 31 : DEPTH;
  localparam int unsigned CapRstI = (DEPTH > 16) ? 16 : DEPTH;
  localparam logic [cfp_pkg::CNT_W-1:0] CapMax = cfp_pkg::CNT_W'(CapMaxI);
  localparam logic [cfp_pkg::CNT_W-1:0] CapRst = cfp_pkg::CNT_W'(CapRstI);
  localparam logic [PW-1:0]             TailRst = PW'(CapRstI - 1);

  // control state
  logic [cfp_pkg::CNT_W-1:0] cap_q, cap_d;
  logic [PW-1:0]             head_q, head_d;
  logic [PW-1:0]             tail_q, tail_d;
  logic [cfp_pkg::CNT_W-1:0] count_q, count_d;
  logic [cfp_pkg::CNT_W-1:0] peak_q, peak_d;
  logic                      err_q, err_d;

  // pipeline registers
  logic                      s1_valid_q;
  cfp_pkg::out_rsp_t         s1_q, s1_d;
  logic                      s1_rd_q, s1_rd_d;
  logic                      out_valid_q;
  cfp_pkg::out_rsp_t         out_q, out_d;

  // ram port
  logic                      ram_we;
  logic [PW-1:0]             ram_waddr;
  logic                      ram_re;
  logic [PW-1:0]             ram_raddr;
  logic [cfp_pkg::DATA_W-1:0] ram_rdata;

  logic                      in_acc;
  logic                      s1_adv;
  logic                      cfg_acc;
  logic [SumW-1:0]           cap_w, head_w, tail_w;
  logic [SumW-1:0]           tail_inc, head_inc, peek_sum;
  logic [PW-1:0]             tail_nxt, head_nxt, peek_addr;
  logic [cfp_pkg::CNT_W-1:0] cfg_cap;
  logic                      ok;
  logic [cfp_pkg::CNT_W-1:0] hw;

  // handshakes
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;

  // ring position arithmetic
  assign cap_w    = SumW'(cap_q);
  assign head_w   = SumW'(head_q);
  assign tail_w   = SumW'(tail_q);
  assign tail_inc = tail_w + SumW'(1);
  assign head_inc = head_w + SumW'(1);
  assign peek_sum = head_w + SumW'(in_req_i.peek_index);
  assign tail_nxt = (tail_inc == cap_w) ? '0 : tail_inc[PW-1:0];
  assign head_nxt = (head_inc == cap_w) ? '0 : head_inc[PW-1:0];
  assign peek_addr = (peek_sum >= cap_w) ? PW'(peek_sum - cap_w) : peek_sum[PW-1:0];

  // capacity clamp
  always_comb begin
    cfg_cap = cfg_data_i;
    if (cfg_data_i == '0) begin
      cfg_cap = cfp_pkg::CNT_W'(1);
    end else if (cfg_data_i > CapMax) begin
      cfg_cap = CapMax;
    end
  end

  // operation decode and state update
  always_comb begin
    cap_d     = cap_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    peak_d    = peak_q;
    err_d     = err_q;
    ok        = 1'b0;
    hw        = '0;
    ram_we    = 1'b0;
    ram_waddr = tail_nxt;
    ram_re    = 1'b0;
    ram_raddr = head_q;
    s1_rd_d   = 1'b0;
    if (in_acc) begin
      case (in_req_i.func)
        cfp_pkg::FUNC_PUSH: begin
          if (count_q < cap_q) begin
            ram_we  = 1'b1;
            tail_d  = tail_nxt;
            count_d = count_q + cfp_pkg::CNT_W'(1);
            if (count_d > peak_q) begin
              peak_d = count_d;
            end
            ok = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
        cfp_pkg::FUNC_POP: begin
          if (count_q != '0) begin
            ram_re  = 1'b1;
            s1_rd_d = 1'b1;
            head_d  = head_nxt;
            count_d = count_q - cfp_pkg::CNT_W'(1);
            ok      = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
        cfp_pkg::FUNC_PEEK: begin
          if (cfp_pkg::CNT_W'(in_req_i.peek_index) < count_q) begin
            ram_re    = 1'b1;
            ram_raddr = peek_addr;
            s1_rd_d   = 1'b1;
            ok        = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
        cfp_pkg::FUNC_CLEAR: begin
          head_d  = '0;
          tail_d  = PW'(cap_q - cfp_pkg::CNT_W'(1));
          count_d = '0;
          peak_d  = '0;
          err_d   = 1'b0;
          ok      = 1'b1;
        end
        cfp_pkg::FUNC_HWM: begin
          hw     = peak_q;
          peak_d = '0;
          ok     = 1'b1;
        end
        default: begin
        end
      endcase
    end
    // capacity write empties the queue
    if (cfg_acc) begin
      cap_d   = cfg_cap;
      head_d  = '0;
      tail_d  = PW'(cfg_cap - cfp_pkg::CNT_W'(1));
      count_d = '0;
      peak_d  = '0;
      err_d   = 1'b0;
    end
  end

  // response fields known at request time
  always_comb begin
    s1_d              = '0;
    s1_d.ok           = ok;
    s1_d.entry_count  = count_d;
    s1_d.is_full      = (count_d == cap_q);
    s1_d.is_empty     = (count_d == '0);
    s1_d.sticky_error = err_d;
    s1_d.high_water   = hw;
  end

  // merge read data into the response
  always_comb begin
    out_d           = s1_q;
    out_d.read_data = s1_rd_q ? ram_rdata : '0;
  end

  // control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CapRst;
      head_q  <= '0;
      tail_q  <= TailRst;
      count_q <= '0;
      peak_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      cap_q   <= cap_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      peak_q  <= peak_d;
      err_q   <= err_d;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q    <= s1_d;
      s1_rd_q <= s1_rd_d;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  // slot storage
  cfp_ram #(
    .WIDTH (cfp_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_req_i.push_data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
